[design/and_popcount_contingency_table_core_defines.svh]
// Shared assertion macros for the contingency table core.
`ifndef AND_POPCOUNT_CONTINGENCY_TABLE_CORE_DEFINES_SVH
`define AND_POPCOUNT_CONTINGENCY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define APCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define APCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/apct_pkg.sv]
`timescale 1ns / 1ps

package apct_pkg;

   localparam int COLS = 3;

   localparam int COUNT_W = 15;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;
   localparam int ENTRY_W = 6;

   // Request commands
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   // CSR map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SIZE   = 2'd2;

   localparam logic [4:0] ROW_COUNT_RST  = 5'd1;
   localparam logic [8:0] WORD_COUNT_RST = 9'd1;
   localparam logic [6:0] OUT_SIZE_RST   = 7'd48;

   typedef struct packed {
      logic [4:0] row_count;
      logic [8:0] word_count;
      logic [6:0] out_size;
   } cfg_type;

   // Microprogram step addresses
   typedef logic [2:0] step_type;
   localparam step_type S_IDLE   = 3'd0;
   localparam step_type S_ENTRY  = 3'd1;
   localparam step_type S_READ   = 3'd2;
   localparam step_type S_DRAIN0 = 3'd3;
   localparam step_type S_DRAIN1 = 3'd4;
   localparam step_type S_EMIT   = 3'd5;
   localparam step_type S_NEXT   = 3'd6;
   localparam step_type S_DONE   = 3'd7;

   // Jump conditions
   typedef logic [2:0] cond_type;
   localparam cond_type C_NEVER        = 3'd0;
   localparam cond_type C_NO_RUN       = 3'd1;
   localparam cond_type C_PAD          = 3'd2;
   localparam cond_type C_MORE_WORDS   = 3'd3;
   localparam cond_type C_OUT_BUSY     = 3'd4;
   localparam cond_type C_MORE_ENTRIES = 3'd5;
   localparam cond_type C_ALWAYS       = 3'd6;

   typedef struct packed {
      logic     idle;
      logic     clr;
      logic     rd;
      logic     emit;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic no_run;
      logic pad;
      logic more_words;
      logic out_busy;
      logic more_entries;
   } stat_type;

endpackage

[design/apct_seq.sv]
`timescale 1ns / 1ps

module apct_seq import apct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   step_type step_ff, step_in;
   logic     taken;

   // Control store: one word per step, fall through unless the condition jumps.
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      w = '0;
      unique case (s)
         S_IDLE: begin
            w.idle = 1'b1; w.cond = C_NO_RUN; w.target = S_IDLE;
         end
         S_ENTRY: begin
            w.clr = 1'b1; w.cond = C_PAD; w.target = S_EMIT;
         end
         S_READ: begin
            w.rd = 1'b1; w.cond = C_MORE_WORDS; w.target = S_READ;
         end
         S_DRAIN0: begin
            w.cond = C_NEVER; w.target = S_IDLE;
         end
         S_DRAIN1: begin
            w.cond = C_NEVER; w.target = S_IDLE;
         end
         S_EMIT: begin
            w.emit = 1'b1; w.cond = C_OUT_BUSY; w.target = S_EMIT;
         end
         S_NEXT: begin
            w.cond = C_MORE_ENTRIES; w.target = S_ENTRY;
         end
         S_DONE: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ctrl = ucode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:        taken = 1'b0;
         C_NO_RUN:       taken = stat.no_run;
         C_PAD:          taken = stat.pad;
         C_MORE_WORDS:   taken = stat.more_words;
         C_OUT_BUSY:     taken = stat.out_busy;
         C_MORE_ENTRIES: taken = stat.more_entries;
         C_ALWAYS:       taken = 1'b1;
         default:        taken = 1'b0;
      endcase
   end

   assign step_in = taken ? ctrl.target : step_type'(step_ff + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[design/apct_dp.sv]
`timescale 1ns / 1ps

`include "and_popcount_contingency_table_core_defines.svh"

module apct_dp import apct_pkg::*; #(
   parameter int ROWS        = 16,
   parameter int WORDS       = 256,
   parameter int OUT_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  cfg_type              cfg,
   output stat_type             stat,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [3:0]           req_row,
   input  logic [7:0]           req_word_index,
   input  logic [63:0]          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ENTRY_W-1:0]   rsp_entry_index,
   output logic [COUNT_W-1:0]   rsp_count,
   output logic                 rsp_last
);

   localparam int KW   = $clog2(WORDS);
   localparam int KCW  = $clog2(WORDS + 1);
   localparam int FD   = ROWS * WORDS;
   localparam int FAW  = $clog2(FD);
   localparam int SD   = COLS * WORDS;
   localparam int SAW  = $clog2(SD);
   localparam int RW   = $clog2(ROWS + 1);
   localparam int TW0  = $clog2(ROWS * COLS + 1);
   localparam int TW   = (TW0 > 7) ? TW0 : 7;
   localparam int EW   = $clog2(OUT_ENTRIES + 1);

   logic [63:0] first_mem  [FD];
   logic [63:0] second_mem [SD];

   logic [63:0]        rd_a_ff, rd_b_ff;
   logic [1:0]         vld_ff;
   logic [6:0]         pc_ff;
   logic [COUNT_W-1:0] acc_ff;
   logic [KW-1:0]      k_ff;
   logic [KCW-1:0]     words_ff;
   logic [EW-1:0]      total_ff, filled_ff, e_ff;
   logic [1:0]         c_ff;
   logic [FAW-1:0]     row_base_ff;

   logic               rsp_valid_ff;
   logic [ENTRY_W-1:0] rsp_entry_index_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   logic           req_fire, run_fire, we_a, we_b, emit_fire;
   logic [FAW-1:0] wa_addr, ra_addr;
   logic [SAW-1:0] wb_addr, rb_addr, col_base;
   logic [RW-1:0]  rows_sat;
   logic [TW-1:0]  filled_full, out_sz, total_pre, total_run, filled_run;
   logic [KCW-1:0] words_run;
   logic [15:0]    sum_wide;
   logic [COUNT_W-1:0] sum_sat;
   logic [6:0]     pc_now;

   function automatic logic [6:0] popcount64(logic [63:0] v);
      logic [63:0] x;
      x = v - ((v >> 1) & 64'h5555_5555_5555_5555);
      x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
      x = (x + (x >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      x = x + (x >> 8);
      x = x + (x >> 16);
      x = x + (x >> 32);
      return x[6:0];
   endfunction

   // ---- request side ----
   assign req_ready = ctrl.idle;
   assign req_fire  = req_valid && req_ready;
   assign run_fire  = req_fire && (req_cmd == CMD_RUN);
   assign we_a = req_fire && (req_cmd == CMD_LOAD_A) && (32'(req_row) < ROWS)
                 && (32'(req_word_index) < WORDS);
   assign we_b = req_fire && (req_cmd == CMD_LOAD_B) && (32'(req_row) < COLS)
                 && (32'(req_word_index) < WORDS);
   assign wa_addr = FAW'(32'(req_row) * WORDS + 32'(req_word_index));
   assign wb_addr = SAW'(32'(req_row) * WORDS + 32'(req_word_index));

   // Run geometry, taken from the CSRs when the run word is accepted
   always_comb begin
      rows_sat    = (32'(cfg.row_count) > ROWS) ? RW'(ROWS) : RW'(cfg.row_count);
      filled_full = TW'(rows_sat) + TW'({rows_sat, 1'b0});
      out_sz      = TW'(cfg.out_size);
      total_pre   = (out_sz > filled_full) ? out_sz : filled_full;
      total_run   = (total_pre > TW'(OUT_ENTRIES)) ? TW'(OUT_ENTRIES) : total_pre;
      filled_run  = (filled_full > total_run) ? total_run : filled_full;
      words_run   = (32'(cfg.word_count) > WORDS) ? KCW'(WORDS) : KCW'(cfg.word_count);
   end

   // ---- table memories ----
   always_comb begin
      unique case (c_ff)
         2'd1:    col_base = SAW'(WORDS);
         2'd2:    col_base = SAW'(2 * WORDS);
         default: col_base = '0;
      endcase
   end

   assign ra_addr = row_base_ff + FAW'(k_ff);
   assign rb_addr = col_base + SAW'(k_ff);

   always_ff @(posedge clock) begin
      if (we_a) begin
         first_mem[wa_addr] <= req_data;
      end
      if (ctrl.rd) begin
         rd_a_ff <= first_mem[ra_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         second_mem[wb_addr] <= req_data;
      end
      if (ctrl.rd) begin
         rd_b_ff <= second_mem[rb_addr];
      end
   end

   // ---- popcount and saturating accumulate ----
   assign pc_now   = popcount64(rd_a_ff & rd_b_ff);
   assign sum_wide = {1'b0, acc_ff} + 16'(pc_ff);
   assign sum_sat  = (sum_wide > 16'(COUNT_MAX)) ? COUNT_MAX : sum_wide[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (vld_ff[0]) begin
         pc_ff <= pc_now;
      end
      if (ctrl.clr) begin
         acc_ff <= '0;
      end else if (vld_ff[1]) begin
         acc_ff <= sum_sat;
      end
      if (run_fire) begin
         words_ff  <= words_run;
         total_ff  <= EW'(total_run);
         filled_ff <= EW'(filled_run);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         k_ff   <= '0;
      end else begin
         vld_ff <= {vld_ff[0], ctrl.rd};
         if (ctrl.clr) begin
            k_ff <= '0;
         end else if (ctrl.rd) begin
            k_ff <= k_ff + KW'(1);
         end
      end
   end

   // ---- entry walk and output register ----
   assign stat.out_busy     = rsp_valid_ff && !rsp_ready;
   assign emit_fire         = ctrl.emit && !stat.out_busy;
   assign stat.no_run       = !(run_fire && (total_run != '0));
   assign stat.pad          = (e_ff >= filled_ff) || (words_ff == '0);
   assign stat.more_words   = (KCW'(k_ff) + KCW'(1)) < words_ff;
   assign stat.more_entries = e_ff < total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff         <= '0;
         c_ff         <= '0;
         row_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (run_fire) begin
            e_ff        <= '0;
            c_ff        <= '0;
            row_base_ff <= '0;
         end else if (emit_fire) begin
            e_ff <= e_ff + EW'(1);
            if (c_ff == 2'd2) begin
               c_ff        <= '0;
               row_base_ff <= row_base_ff + FAW'(WORDS);
            end else begin
               c_ff <= c_ff + 2'd1;
            end
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_entry_index_ff <= ENTRY_W'(e_ff);
         rsp_count_ff       <= acc_ff;
         rsp_last_ff        <= (EW'(e_ff + EW'(1)) == total_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_entry_index_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   `APCT_ASSERT_IMP(a_rd_in_row, clock, reset, ctrl.rd, KCW'(k_ff) < words_ff, "word read past row end")
   `APCT_ASSERT_IMP(a_emit_drained, clock, reset, ctrl.emit, vld_ff == 2'b00, "emit with reads in flight")
   `APCT_ASSERT_NXT(a_pad_zero, clock, reset, emit_fire && stat.pad, rsp_count_ff == '0, "padding entry with nonzero count")
   `APCT_ASSERT_IMP(a_entry_bound, clock, reset, !ctrl.idle, e_ff <= total_ff, "entry counter past run length")

endmodule

[design/and_popcount_contingency_table_core.sv]
`timescale 1ns / 1ps

// Channel | Ports                                          | Handshake
// req     | req_cmd, req_row, req_word_index, req_data     | req_valid / req_ready
// rsp     | rsp_entry_index, rsp_count, rsp_last           | rsp_valid / rsp_ready
// csr     | csr_index, csr_data                            | csr_wr_en, no wait
//
// Load words are written on accept; req_ready is high whenever no run is in progress.
// A run word starts the entry walk: each filled entry streams its row and column
// words through the table memories one word per cycle, then drains the popcount pipe.
// Synchronous active-high reset; the tables hold no reset value, so no clearing pass.
// A stalled rsp holds the sequencer in its emit step; the next req word waits for idle.

module and_popcount_contingency_table_core import apct_pkg::*; #(
   parameter int ROWS        = 16,
   parameter int WORDS       = 256,
   parameter int OUT_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [3:0]            req_row,
   input  logic [7:0]            req_word_index,
   input  logic [63:0]           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ENTRY_W-1:0]    rsp_entry_index,
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   ctrl_type ctrl;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count  <= ROW_COUNT_RST;
         cfg_ff.word_count <= WORD_COUNT_RST;
         cfg_ff.out_size   <= OUT_SIZE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW_COUNT:  cfg_ff.row_count  <= csr_data[4:0];
            CSR_WORD_COUNT: cfg_ff.word_count <= csr_data[8:0];
            CSR_OUT_SIZE:   cfg_ff.out_size   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   apct_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   apct_dp #(
      .ROWS        (ROWS),
      .WORDS       (WORDS),
      .OUT_ENTRIES (OUT_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg_ff),
      .stat            (stat),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_row         (req_row),
      .req_word_index  (req_word_index),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_index (rsp_entry_index),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_last)
   );

endmodule
